// ----- design/wbss_pkg.sv -----
// Shared types and constants for the wildcard byte signature scanner.
// Used by wbss_cell and wildcard_byte_signature_scanner. No dependencies.
package wbss_pkg;

   // Window depth (cells in the chain) and byte counter width
   localparam int MAX_PATTERN = 16;
   localparam int COUNT_WIDTH = 32;

   // Signature storage is fixed by the register map: 16 bytes
   localparam int SIG_BYTES     = 16;
   localparam int SIG_IDX_WIDTH = 4;
   localparam int LEN_WIDTH     = 5;
   localparam int ADDR_WIDTH    = 64;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 64;

   // Register indexes on the csr channel
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_CARE_MASK    = 3'd2,
      CSR_PATTERN_LEN  = 3'd3,
      CSR_BASE_ADDRESS = 3'd4,
      CSR_FIRST_ONLY   = 3'd5
   } csr_index_type;

   // Input beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } wbss_req_type;

   // Result beat
   typedef struct packed {
      logic                  match_valid;
      logic [ADDR_WIDTH-1:0] match_address;
      logic                  end_of_scan;
   } wbss_rsp_type;

   // Per-cell compare setup, derived from the signature registers
   typedef struct packed {
      logic [7:0] sig_byte;
      logic       must_match;
   } wbss_lane_type;

endpackage

// ----- design/wbss_cell.sv -----
// One window cell: holds one byte of the sliding window and the compare
// result of that byte against its aligned signature byte. Uses wbss_pkg.
module wbss_cell
   import wbss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          shift_en,
   input  logic          clear,
   input  logic [7:0]    byte_in,
   input  wbss_lane_type lane,
   output logic [7:0]    byte_out,
   output logic          eq_out
);

   logic [7:0] byte_ff, byte_in_next;
   logic       eq_ff, eq_in;

   // compare the byte entering this cell; window empties after the final byte
   always_comb begin
      eq_in        = !lane.must_match || (byte_in == lane.sig_byte);
      byte_in_next = clear ? 8'd0 : byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
         eq_ff   <= 1'b0;
      end else if (shift_en) begin
         byte_ff <= byte_in_next;
         eq_ff   <= eq_in;
      end
   end

   assign byte_out = byte_ff;
   assign eq_out   = eq_ff;

endmodule

// ----- design/wildcard_byte_signature_scanner.sv -----
// Top level of the wildcard byte signature scanner: csr registers, the chain
// of wbss_cell window cells, match stage and result register. Uses wbss_pkg.
//
// The block takes one byte beat per clock cycle unless the input stalls as
// described below. On accept the byte enters a chain of MAX_PATTERN cells
// that shift the window and compare each incoming byte against its aligned
// signature byte, and the window stage registers it; when the window stage
// moves on, the per-cell compare bits are combined, the start address is
// formed and a result beat is loaded into the output register.
// Bytes that produce no result pass through without using the output
// register. Input stalls only when the byte in the window stage needs a result
// beat while the output register still holds one that the sink is not taking.
// Write the csr registers only while the block is idle.
module wildcard_byte_signature_scanner
   import wbss_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // byte input channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  wbss_req_type              req_data,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output wbss_rsp_type              rsp_data,
   // csr write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_data
);

   // csr registers
   logic [63:0]            pat_low_ff, pat_high_ff;
   logic [SIG_BYTES-1:0]   care_ff;
   logic [LEN_WIDTH-1:0]   len_ff;
   logic [ADDR_WIDTH-1:0]  base_ff;
   logic                   first_only_ff;

   // scan state
   logic [COUNT_WIDTH-1:0] seen_ff, seen_in, seen_inc;
   logic                   found_ff, found_in;

   // window stage
   logic                   a_valid_ff, a_valid_in;
   logic                   a_last_ff;
   logic [COUNT_WIDTH-1:0] a_seen_ff;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   wbss_rsp_type           rsp_ff;

   logic                   req_go, a_go, out_free, need_out;
   logic                   len_ok, all_eq, hit;
   logic [ADDR_WIDTH-1:0]  match_addr;

   logic [7:0]             sig [SIG_BYTES];
   wbss_lane_type          lanes [MAX_PATTERN];
   logic [7:0]             chain [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0] eq_bits;

   assign csr_ready = 1'b1;

   // csr writes; indexes past the map are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff    <= '0;
         pat_high_ff   <= '0;
         care_ff       <= '0;
         len_ff        <= '0;
         base_ff       <= '0;
         first_only_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pat_low_ff    <= csr_data;
            CSR_PATTERN_HIGH: pat_high_ff   <= csr_data;
            CSR_CARE_MASK:    care_ff       <= csr_data[SIG_BYTES-1:0];
            CSR_PATTERN_LEN:  len_ff        <= csr_data[LEN_WIDTH-1:0];
            CSR_BASE_ADDRESS: base_ff       <= csr_data[ADDR_WIDTH-1:0];
            CSR_FIRST_ONLY:   first_only_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // signature bytes as an array
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         sig[i]   = pat_low_ff[8*i +: 8];
         sig[i+8] = pat_high_ff[8*i +: 8];
      end
   end

   // lane setup: cell k (age k) lines up with signature byte len-1-k
   always_comb begin
      logic [LEN_WIDTH-1:0] idx;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         idx = len_ff - LEN_WIDTH'(1) - LEN_WIDTH'(k);
         lanes[k].sig_byte   = sig[idx[SIG_IDX_WIDTH-1:0]];
         lanes[k].must_match = (LEN_WIDTH'(k) < len_ff)
                             && care_ff[idx[SIG_IDX_WIDTH-1:0]];
      end
   end

   // handshakes
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign need_out  = hit || a_last_ff;
   assign a_go      = a_valid_ff && (!need_out || out_free);
   assign req_ready = !a_valid_ff || a_go;
   assign req_go    = req_valid && req_ready;

   // chain of window cells, newest byte enters cell 0
   assign chain[0] = req_data.data_byte;

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
      wbss_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (req_go),
         .clear    (req_data.last_byte),
         .byte_in  (chain[k]),
         .lane     (lanes[k]),
         .byte_out (chain[k+1]),
         .eq_out   (eq_bits[k])
      );
   end

   // saturating byte count of the range, cleared after the final byte
   always_comb begin
      seen_inc = (seen_ff == {COUNT_WIDTH{1'b1}}) ? seen_ff : seen_ff + COUNT_WIDTH'(1);
      seen_in  = seen_ff;
      if (req_go) begin
         seen_in = req_data.last_byte ? '0 : seen_inc;
      end
   end

   // match decision for the byte in the window stage
   always_comb begin
      len_ok     = (len_ff != '0) && (len_ff <= LEN_WIDTH'(MAX_PATTERN));
      all_eq     = &eq_bits;
      hit        = a_valid_ff && len_ok && all_eq
                && (a_seen_ff >= COUNT_WIDTH'(len_ff))
                && !(first_only_ff && found_ff);
      match_addr = base_ff + ADDR_WIDTH'(a_seen_ff) - ADDR_WIDTH'(len_ff);
   end

   // first-match flag
   always_comb begin
      found_in = found_ff;
      if (a_go) begin
         if (a_last_ff) begin
            found_in = 1'b0;
         end else if (hit) begin
            found_in = 1'b1;
         end
      end
   end

   always_comb begin
      a_valid_in = req_go ? 1'b1 : (a_go ? 1'b0 : a_valid_ff);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (a_go && need_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         found_ff     <= 1'b0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         found_ff     <= found_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // window stage payload
   always_ff @(posedge clock) begin
      if (req_go) begin
         a_last_ff <= req_data.last_byte;
         a_seen_ff <= seen_inc;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (a_go && need_out) begin
         rsp_ff.match_valid   <= hit;
         rsp_ff.match_address <= hit ? match_addr : '0;
         rsp_ff.end_of_scan   <= a_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
